// ----- design/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg - shared types and constants
// Vertex store geometry, arithmetic widths and sequencer states for the
// triangle tangent/bitangent unit.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int VERTEX_DEPTH = 1024;
	localparam int VADDR_W      = $clog2(VERTEX_DEPTH);
	localparam int VIDX_W       = 10;
	localparam int FIX_W        = 32;
	localparam int DELTA_W      = FIX_W + 1;
	localparam int PROD_W       = 2 * DELTA_W;
	localparam int NUM_W        = PROD_W + 1;
	localparam int MAG_W        = PROD_W;
	localparam int QUO_W        = FIX_W + 2;
	localparam int DIV_W        = MAG_W + QUO_W;
	localparam int FRAC_W       = 16;
	localparam int NUM_PRODS    = 14;
	localparam int NUM_COMP     = 6;

	localparam logic ACT_VERTEX   = 1'b0;
	localparam logic ACT_TRIANGLE = 1'b1;

	typedef struct packed {
		logic [FIX_W-1:0] x;
		logic [FIX_W-1:0] y;
		logic [FIX_W-1:0] z;
		logic [FIX_W-1:0] u;
		logic [FIX_W-1:0] v;
	} vtx_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_DELTA = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DSET  = 7'b0010000,
		ST_DSTEP = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

// ----- design/ttb_ram.sv -----
// ----------------------------------------------------------------------------
// ttb_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/triangle_tangent_bitangent.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent - per-triangle tangent and bitangent
// Vertex store plus a sequencer around one shared multiplier and one
// restoring divider; Q16.16 results, saturated, zero on degenerate UV.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in        in   in_valid/in_ready    action, vertex_index, pos_*, tex_*, corner_*
//  out       out  out_valid/out_ready  tangent_*, bitangent_*, degenerate
//
//  A vertex write leaves the input ready. A triangle passes through the read,
//  delta and multiply states, then the divider, which yields one quotient bit
//  per cycle, for each of the 6 components, then a hand-off state; degenerate
//  triangles skip the divider. The finished result sits in the output register;
//  a new request is taken while it waits, but the next result waits for the
//  register to empty. Reset clears control only; vertex entries are undefined
//  until written.
module triangle_tangent_bitangent
	import ttb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic [VIDX_W-1:0]        vertex_index,
	input  logic signed [FIX_W-1:0]  pos_x,
	input  logic signed [FIX_W-1:0]  pos_y,
	input  logic signed [FIX_W-1:0]  pos_z,
	input  logic signed [FIX_W-1:0]  tex_u,
	input  logic signed [FIX_W-1:0]  tex_v,
	input  logic [VIDX_W-1:0]        corner_a,
	input  logic [VIDX_W-1:0]        corner_b,
	input  logic [VIDX_W-1:0]        corner_c,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [FIX_W-1:0]  tangent_x,
	output logic signed [FIX_W-1:0]  tangent_y,
	output logic signed [FIX_W-1:0]  tangent_z,
	output logic signed [FIX_W-1:0]  bitangent_x,
	output logic signed [FIX_W-1:0]  bitangent_y,
	output logic signed [FIX_W-1:0]  bitangent_z,
	output logic                     degenerate
);

	function automatic logic signed [DELTA_W-1:0] dlt(logic [FIX_W-1:0] p, logic [FIX_W-1:0] q);
		return $signed({p[FIX_W-1], p}) - $signed({q[FIX_W-1], q});
	endfunction

	state_t state_q;
	logic [5:0] cnt_q;
	logic [2:0] k_q;

	logic [VIDX_W-1:0] ca_q, cb_q, cc_q;
	vtx_t va_q, vb_q, vc_q;
	vtx_t wr_ent, rd_ent;
	logic ram_we;
	logic [VADDR_W-1:0] ram_raddr;

	logic signed [DELTA_W-1:0] dp1_q [3];
	logic signed [DELTA_W-1:0] dp2_q [3];
	logic signed [DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;

	logic signed [DELTA_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      pv_s1;
	logic [3:0]                pidx_s1;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [NUM_W-1:0]   diff;
	logic signed [NUM_W-1:0]   det_q;
	logic signed [NUM_W-1:0]   num_q [NUM_COMP];
	logic [2:0]                jm1;

	logic signed [NUM_W-1:0] nsel, nabs, dabs;
	logic [DIV_W-1:0] rem_q, dsh_q;
	logic [QUO_W-1:0] q_q, q_next, lim;
	logic             neg_q, ge;
	logic [FIX_W-1:0] qs, res_fin;
	logic [FIX_W-1:0] res_q [NUM_COMP];
	logic             degen_q;

	logic [FIX_W-1:0] out_q [NUM_COMP];
	logic             out_degen_q, out_valid_q;

	assign in_ready = (state_q == ST_IDLE);
	assign ram_we   = in_valid && in_ready && (action == ACT_VERTEX);
	assign wr_ent   = '{x: pos_x, y: pos_y, z: pos_z, u: tex_u, v: tex_v};

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    ram_raddr = ca_q[VADDR_W-1:0];
			2'd1:    ram_raddr = cb_q[VADDR_W-1:0];
			default: ram_raddr = cc_q[VADDR_W-1:0];
		endcase
	end

	ttb_ram #(
		.WIDTH ($bits(vtx_t)),
		.DEPTH (VERTEX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vertex_index[VADDR_W-1:0]),
		.wdata (wr_ent),
		.raddr (ram_raddr),
		.rdata (rd_ent)
	);

	// multiplier operand order: det, tangent x/y/z, bitangent x/y/z, two terms each
	always_comb begin
		case (cnt_q[3:0])
			4'd0:    begin mul_a = du1_q;    mul_b = dv2_q; end
			4'd1:    begin mul_a = dv1_q;    mul_b = du2_q; end
			4'd2:    begin mul_a = dp1_q[0]; mul_b = dv2_q; end
			4'd3:    begin mul_a = dp2_q[0]; mul_b = dv1_q; end
			4'd4:    begin mul_a = dp1_q[1]; mul_b = dv2_q; end
			4'd5:    begin mul_a = dp2_q[1]; mul_b = dv1_q; end
			4'd6:    begin mul_a = dp1_q[2]; mul_b = dv2_q; end
			4'd7:    begin mul_a = dp2_q[2]; mul_b = dv1_q; end
			4'd8:    begin mul_a = dp2_q[0]; mul_b = du1_q; end
			4'd9:    begin mul_a = dp1_q[0]; mul_b = du2_q; end
			4'd10:   begin mul_a = dp2_q[1]; mul_b = du1_q; end
			4'd11:   begin mul_a = dp1_q[1]; mul_b = du2_q; end
			4'd12:   begin mul_a = dp2_q[2]; mul_b = du1_q; end
			default: begin mul_a = dp1_q[2]; mul_b = du2_q; end
		endcase
	end

	assign diff = NUM_W'(acc_q) - NUM_W'(prod_s1);
	assign jm1  = 3'(pidx_s1[3:1] - 3'd1);

	assign nsel = num_q[k_q];
	assign nabs = nsel[NUM_W-1] ? -nsel : nsel;
	assign dabs = det_q[NUM_W-1] ? -det_q : det_q;

	assign ge      = (rem_q >= dsh_q);
	assign q_next  = {q_q[QUO_W-2:0], ge};
	assign lim     = neg_q ? QUO_W'(34'h0_8000_0000) : QUO_W'(34'h0_7FFF_FFFF);
	assign qs      = (q_next > lim) ? lim[FIX_W-1:0] : q_next[FIX_W-1:0];
	assign res_fin = neg_q ? (FIX_W'(0) - qs) : qs;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		pidx_s1 <= cnt_q[3:0];
		if (in_valid && in_ready && action == ACT_TRIANGLE) begin
			ca_q <= corner_a;
			cb_q <= corner_b;
			cc_q <= corner_c;
		end
		if (state_q == ST_READ) begin
			case (cnt_q[1:0])
				2'd1:    va_q <= rd_ent;
				2'd2:    vb_q <= rd_ent;
				2'd3:    vc_q <= rd_ent;
				default: ;
			endcase
		end
		if (state_q == ST_DELTA) begin
			dp1_q[0] <= dlt(vb_q.x, va_q.x);
			dp1_q[1] <= dlt(vb_q.y, va_q.y);
			dp1_q[2] <= dlt(vb_q.z, va_q.z);
			dp2_q[0] <= dlt(vc_q.x, va_q.x);
			dp2_q[1] <= dlt(vc_q.y, va_q.y);
			dp2_q[2] <= dlt(vc_q.z, va_q.z);
			du1_q    <= dlt(vb_q.u, va_q.u);
			dv1_q    <= dlt(vb_q.v, va_q.v);
			du2_q    <= dlt(vc_q.u, va_q.u);
			dv2_q    <= dlt(vc_q.v, va_q.v);
		end
		if (pv_s1) begin
			if (!pidx_s1[0]) begin
				acc_q <= prod_s1;
			end else if (pidx_s1[3:1] == 3'd0) begin
				det_q <= diff;
			end else begin
				num_q[jm1] <= diff;
			end
		end
		if (state_q == ST_DSET) begin
			rem_q <= DIV_W'({nabs[MAG_W-1:0], FRAC_W'(0)});
			dsh_q <= DIV_W'({dabs[MAG_W-1:0], (QUO_W-1)'(0)});
			neg_q <= nsel[NUM_W-1] ^ det_q[NUM_W-1];
			q_q   <= '0;
			if (det_q == '0) begin
				for (int i = 0; i < NUM_COMP; i++) begin
					res_q[i] <= '0;
				end
			end
		end
		if (state_q == ST_DSTEP) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			q_q   <= q_next;
			if (cnt_q == 6'(QUO_W - 1)) begin
				res_q[k_q] <= res_fin;
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				out_q[i] <= res_q[i];
			end
			out_degen_q <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			pv_s1       <= 1'b0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_MUL) && (cnt_q < 6'(NUM_PRODS));
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && action == ACT_TRIANGLE) begin
						state_q <= ST_READ;
						cnt_q   <= '0;
						degen_q <= 1'b0;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					state_q <= ST_MUL;
					cnt_q   <= '0;
				end
				ST_MUL: begin
					if (cnt_q < 6'(NUM_PRODS)) begin
						cnt_q <= cnt_q + 6'd1;
					end
					if (pv_s1 && pidx_s1 == 4'(NUM_PRODS - 1)) begin
						state_q <= ST_DSET;
						k_q     <= '0;
					end
				end
				ST_DSET: begin
					cnt_q <= '0;
					if (det_q == '0) begin
						degen_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DSTEP;
					end
				end
				ST_DSTEP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(QUO_W - 1)) begin
						if (k_q == 3'(NUM_COMP - 1)) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_DSET;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign tangent_x   = out_q[0];
	assign tangent_y   = out_q[1];
	assign tangent_z   = out_q[2];
	assign bitangent_x = out_q[3];
	assign bitangent_y = out_q[4];
	assign bitangent_z = out_q[5];
	assign degenerate  = out_degen_q;

endmodule

// ----- design/ttb_checker.sv -----
// ----------------------------------------------------------------------------
// ttb_checker - port-level checks for the tangent/bitangent unit
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module ttb_checker
	import ttb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    action,
	input logic [VIDX_W-1:0]       vertex_index,
	input logic signed [FIX_W-1:0] pos_x,
	input logic signed [FIX_W-1:0] pos_y,
	input logic signed [FIX_W-1:0] pos_z,
	input logic signed [FIX_W-1:0] tex_u,
	input logic signed [FIX_W-1:0] tex_v,
	input logic [VIDX_W-1:0]       corner_a,
	input logic [VIDX_W-1:0]       corner_b,
	input logic [VIDX_W-1:0]       corner_c,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [FIX_W-1:0] tangent_x,
	input logic signed [FIX_W-1:0] tangent_y,
	input logic signed [FIX_W-1:0] tangent_z,
	input logic signed [FIX_W-1:0] bitangent_x,
	input logic signed [FIX_W-1:0] bitangent_y,
	input logic signed [FIX_W-1:0] bitangent_z,
	input logic                    degenerate
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tangent_x) && $stable(bitangent_z)
		&& $stable(degenerate))
		else $error("result changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 0 && tangent_y == 0 && tangent_z == 0
		&& bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)
		else $error("degenerate result with non-zero vectors");

	a_tri_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_TRIANGLE |=> !in_ready)
		else $error("ready straight after a triangle request");

	a_vtx_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_VERTEX |=> in_ready)
		else $error("vertex write stalled the input");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_TRIANGLE |=> ##1 !$rose(out_valid))
		else $error("result too soon after request");

endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (.*);

// ----- tb/tangent_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tangent_frame_checker - request/result scoreboard
// Watches both channels of the tangent/bitangent unit. It mirrors the vertex
// store on accepted writes and predicts each triangle's frame at full
// precision. Each delivered result is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module tangent_frame_checker
	import ttb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic                    action,
	input  logic [VIDX_W-1:0]       vertex_index,
	input  logic signed [FIX_W-1:0] pos_x,
	input  logic signed [FIX_W-1:0] pos_y,
	input  logic signed [FIX_W-1:0] pos_z,
	input  logic signed [FIX_W-1:0] tex_u,
	input  logic signed [FIX_W-1:0] tex_v,
	input  logic [VIDX_W-1:0]       corner_a,
	input  logic [VIDX_W-1:0]       corner_b,
	input  logic [VIDX_W-1:0]       corner_c,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [FIX_W-1:0] tangent_x,
	input  logic signed [FIX_W-1:0] tangent_y,
	input  logic signed [FIX_W-1:0] tangent_z,
	input  logic signed [FIX_W-1:0] bitangent_x,
	input  logic signed [FIX_W-1:0] bitangent_y,
	input  logic signed [FIX_W-1:0] bitangent_z,
	input  logic                    degenerate,
	output int                      errors,
	output int                      pending
);

	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic signed [66:0] wide_t;

	typedef struct {
		fix_t t[3];
		fix_t b[3];
		logic degen;
	} frame_t;

	vtx_t vertices[VERTEX_DEPTH];
	frame_t expected_frames[$];

	function automatic fix_t scaled_quotient(wide_t num, wide_t den);
		logic signed [127:0] n, d, q;
		n = num;
		d = den;
		n = n <<< FRAC_W;
		q = n / d;
		if (q > 128'sd2147483647)
			return 32'h7fffffff;
		if (q < -128'sd2147483648)
			return 32'h80000000;
		return q[31:0];
	endfunction

	function automatic frame_t tangent_frame(int ia, int ib, int ic);
		vtx_t a, b, c;
		logic signed [32:0] dp1[3], dp2[3], du1, dv1, du2, dv2;
		wide_t det, nt, nb;
		frame_t f;
		a = vertices[ia];
		b = vertices[ib];
		c = vertices[ic];
		dp1[0] = $signed(b.x) - $signed(a.x);
		dp1[1] = $signed(b.y) - $signed(a.y);
		dp1[2] = $signed(b.z) - $signed(a.z);
		dp2[0] = $signed(c.x) - $signed(a.x);
		dp2[1] = $signed(c.y) - $signed(a.y);
		dp2[2] = $signed(c.z) - $signed(a.z);
		du1 = $signed(b.u) - $signed(a.u);
		dv1 = $signed(b.v) - $signed(a.v);
		du2 = $signed(c.u) - $signed(a.u);
		dv2 = $signed(c.v) - $signed(a.v);
		det = du1 * dv2 - dv1 * du2;
		f.degen = (det == 0);
		for (int k = 0; k < 3; k++) begin
			if (f.degen) begin
				f.t[k] = '0;
				f.b[k] = '0;
			end else begin
				nt = dp1[k] * dv2 - dp2[k] * dv1;
				nb = dp2[k] * du1 - dp1[k] * du2;
				f.t[k] = scaled_quotient(nt, det);
				f.b[k] = scaled_quotient(nb, det);
			end
		end
		return f;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		frame_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				report("unexpected result", tangent_x, 0);
			end else begin
				e = expected_frames.pop_front();
				if (tangent_x !== e.t[0]) report("tangent_x", tangent_x, e.t[0]);
				if (tangent_y !== e.t[1]) report("tangent_y", tangent_y, e.t[1]);
				if (tangent_z !== e.t[2]) report("tangent_z", tangent_z, e.t[2]);
				if (bitangent_x !== e.b[0]) report("bitangent_x", bitangent_x, e.b[0]);
				if (bitangent_y !== e.b[1]) report("bitangent_y", bitangent_y, e.b[1]);
				if (bitangent_z !== e.b[2]) report("bitangent_z", bitangent_z, e.b[2]);
				if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			if (action == ACT_VERTEX)
				vertices[vertex_index] <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
			else
				expected_frames.insert(expected_frames.size(),
					tangent_frame(corner_a, corner_b, corner_c));
		end
		pending <= expected_frames.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end

endmodule

// ----- tb/triangle_tangent_bitangent_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_tb - tangent/bitangent unit testbench
// Directed extremes and degenerate triangles, then random vertex writes and
// triangles over written entries, with random gaps, stalls and one long
// output hold-off. Checking is done by the scoreboard beside the block.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_tb;
	import ttb_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int RANDOM_ITEMS = 1130;

	logic clk, arst_n;
	logic in_valid, in_ready, action;
	logic [VIDX_W-1:0] vertex_index, corner_a, corner_b, corner_c;
	logic signed [FIX_W-1:0] pos_x, pos_y, pos_z, tex_u, tex_v;
	logic out_valid, out_ready, degenerate;
	logic signed [FIX_W-1:0] tangent_x, tangent_y, tangent_z;
	logic signed [FIX_W-1:0] bitangent_x, bitangent_y, bitangent_z;
	int errors, pending, idle_cycles, results_seen;
	bit written[VERTEX_DEPTH];
	int written_list[$];

	triangle_tangent_bitangent uut (.*);

	tangent_frame_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// gap or stall length; some stretches run flat out
	function automatic int draw_wait(int phase);
		if (phase % 3 == 0)
			return 0;
		return $urandom_range(0, 5);
	endfunction

	function automatic logic [31:0] rand_fix();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return $urandom;
			default: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
		endcase
	endfunction

	function automatic int pick_corner();
		return written_list[$urandom_range(0, written_list.size() - 1)];
	endfunction

	task automatic send(logic act, int idx, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] tu, logic [31:0] tv, int ca, int cb, int cc, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		vertex_index <= VIDX_W'(idx);
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		tex_u <= tu;
		tex_v <= tv;
		corner_a <= VIDX_W'(ca);
		corner_b <= VIDX_W'(cb);
		corner_c <= VIDX_W'(cc);
		do @(posedge clk); while (!in_ready);
		if (act == ACT_VERTEX && !written[idx]) begin
			written[idx] = 1;
			written_list.insert(written_list.size(), idx);
		end
	endtask

	task automatic write_vertex(int idx, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] tu, logic [31:0] tv, int gap);
		send(ACT_VERTEX, idx, px, py, pz, tu, tv, $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), gap);
	endtask

	task automatic triangle(int ca, int cb, int cc, int gap);
		send(ACT_TRIANGLE, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
			$urandom, $urandom, ca, cb, cc, gap);
	endtask

	// result side
	initial begin
		int hold;
		out_ready <= 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(results_seen / 50);
			if (results_seen == 40)
				hold = 1500;
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("triangle_tangent_bitangent: mismatch");
			$finish;
		end
	end

	initial begin
		int ca, cb, cc;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_VERTEX;
		vertex_index <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		tex_u <= '0;
		tex_v <= '0;
		corner_a <= '0;
		corner_b <= '0;
		corner_c <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of position and texture range
		write_vertex(0, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 0);
		write_vertex(1023, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 1);
		write_vertex(341, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 0);
		write_vertex(682, 32'h00010000, 32'h00020000, 32'hffff0000,
			32'h00010000, 32'h00000000, 2);
		write_vertex(1, 32'h00000000, 32'h00010000, 32'h00000000,
			32'h00000000, 32'h00010000, 0);
		write_vertex(2, 32'h00030000, 32'h00030000, 32'h00030000,
			32'h00020000, 32'h00020000, 0);
		write_vertex(3, 32'h00000001, 32'hffffffff, 32'h00000002,
			32'h00000001, 32'h00000000, 0);
		write_vertex(4, 32'h00000000, 32'h00000001, 32'hffffffff,
			32'h00000000, 32'h00000001, 3);
		triangle(0, 682, 1, 0);
		triangle(0, 0, 0, 0);       // coincident corners
		triangle(0, 1023, 341, 1);  // widest deltas
		triangle(1023, 341, 0, 0);
		triangle(341, 0, 1023, 0);
		triangle(0, 1, 2, 0);
		triangle(0, 2, 2, 2);       // repeated corner
		triangle(0, 3, 4, 0);       // tiny determinant
		triangle(0, 4, 3, 0);
		triangle(682, 0, 2, 0);     // non-collinear texture coordinates
		triangle(1023, 1023, 0, 0);
		triangle(1, 682, 1023, 5);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (written_list.size() < 3 || $urandom_range(0, 99) < 55) begin
				write_vertex($urandom_range(0, 1023), rand_fix(), rand_fix(), rand_fix(),
					rand_fix(), rand_fix(), draw_wait(n / 60));
			end else begin
				ca = pick_corner();
				cb = pick_corner();
				cc = pick_corner();
				if ($urandom_range(0, 9) == 0)
					cc = cb;
				triangle(ca, cb, cc, draw_wait(n / 60));
			end
		end
		in_valid <= 1'b0;

		while (pending != 0 || checker_i.expected_frames.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("triangle_tangent_bitangent: match");
		else
			$display("triangle_tangent_bitangent: mismatch");
		$finish;
	end

endmodule
